// File: src/modinv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// modinv_pkg
// Types and constants shared by the modular inverse controller and datapath.
// ----------------------------------------------------------------------------
package modinv_pkg;

  localparam int ValW    = 31;
  localparam int CoefW   = 34;
  localparam int CntW    = 5;
  localparam logic [CntW-1:0] DivLast = CntW'(ValW - 1);
  localparam logic [ValW-1:0] ModReset = 31'd1073643521;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic update;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic r1_zero;
    logic div_last;
    logic out_blocked;
  } status_t;

endpackage

`default_nettype wire

// File: src/modinv_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// modinv_in_if
// Input channel: one value per beat.
// ----------------------------------------------------------------------------
interface modinv_in_if;
  logic        valid;
  logic        ready;
  logic [30:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// File: src/modinv_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// modinv_out_if
// Output channel: one inverse per beat.
// ----------------------------------------------------------------------------
interface modinv_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] inverse;

  modport source (output valid, output inverse, input ready);
  modport sink   (input valid, input inverse, output ready);
endinterface

`default_nettype wire

// File: src/modinv_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// modinv_datapath
// Remainder and coefficient registers, bit-serial divider with shift-add
// quotient times coefficient, and the output register.
// ----------------------------------------------------------------------------
module modinv_datapath
  import modinv_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cmd_t            cmd,
  output status_t              status,
  input  wire logic [ValW-1:0] modulus,
  input  wire logic [ValW-1:0] value,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [ValW-1:0]      inverse
);

  logic        [ValW-1:0]  r0;
  logic        [ValW-1:0]  r1;
  logic signed [CoefW-1:0] c0;
  logic signed [CoefW-1:0] c1;
  logic        [ValW-1:0]  rem;
  logic        [ValW-1:0]  dvd;
  logic signed [CoefW-1:0] prod;
  logic        [CntW-1:0]  cnt;

  logic        [ValW:0]    shifted;
  logic                    ge;
  logic        [ValW:0]    diff;
  logic        [ValW-1:0]  rem_next;
  logic signed [CoefW-1:0] prod_next;
  logic signed [CoefW-1:0] lifted;

  assign shifted   = {rem, dvd[ValW-1]};
  assign ge        = shifted >= {1'b0, r1};
  assign diff      = shifted - {1'b0, r1};
  assign rem_next  = ge ? diff[ValW-1:0] : shifted[ValW-1:0];
  assign prod_next = (prod <<< 1) + (ge ? c1 : '0);
  assign lifted    = c0[CoefW-1] ? c0 + $signed({{(CoefW-ValW){1'b0}}, modulus}) : c0;

  assign status.r1_zero     = (r1 == '0);
  assign status.div_last    = (cnt == DivLast);
  assign status.out_blocked = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r0 <= modulus;
      r1 <= value;
      c0 <= '0;
      c1 <= CoefW'(1);
    end else if (cmd.update) begin
      r0 <= r1;
      r1 <= rem;
      c0 <= c1;
      c1 <= c0 - prod;
    end
    if (cmd.div_init) begin
      rem  <= '0;
      dvd  <= r0;
      prod <= '0;
      cnt  <= '0;
    end else if (cmd.div_step) begin
      rem  <= rem_next;
      dvd  <= {dvd[ValW-2:0], 1'b0};
      prod <= prod_next;
      cnt  <= cnt + 1'b1;
    end
    if (cmd.finish) begin
      inverse <= lifted[ValW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: src/modinv_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// modinv_ctrl
// Sequencer for the Euclid iterations: check, divide bit by bit, update.
// ----------------------------------------------------------------------------
module modinv_ctrl
  import modinv_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = status.r1_zero ? ST_FINISH : ST_DIV;
      end
      ST_DIV: begin
        if (status.div_last) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = ST_CHECK;
      end
      ST_FINISH: begin
        if (!status.out_blocked) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CHECK: begin
        cmd.div_init = !status.r1_zero;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = !status.out_blocked;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/modular_inverse_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// modular_inverse_unit
// Inverse of value modulo a configured modulus by the extended Euclidean
// algorithm.
// ----------------------------------------------------------------------------
// One value is taken at a time. Each Euclid iteration runs one check, the
// bit-serial restoring divider (which also forms quotient times coefficient
// by shift-add), and one update. The number of iterations is at most about
// 45 for 31-bit operands. A zero value gives 0. The modulus is written
// through cfg_we / cfg_wdata and resets to 1073643521; the user must write
// it only while no item is in flight, and the block itself does not enforce
// this. The finished result waits in an output register so the next value
// can be accepted meanwhile.
// ----------------------------------------------------------------------------
module modular_inverse_unit
  import modinv_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [ValW-1:0] cfg_wdata,
  modinv_in_if.sink            in_ch,
  modinv_out_if.source         out_ch
);

  logic [ValW-1:0] modulus;
  cmd_t            cmd;
  status_t         status;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= ModReset;
    end else if (cfg_we) begin
      modulus <= cfg_wdata;
    end
  end

  modinv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  modinv_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .modulus   (modulus),
    .value     (in_ch.value),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .inverse   (out_ch.inverse)
  );

endmodule

`default_nettype wire
